// ----- hw/rtl/multi_revolution_bit_vote_top_macros.svh -----
// Assertion helpers for the bit vote block.
// Both sample on clk and are off while rst_n is low.
`ifndef MULTI_REVOLUTION_BIT_VOTE_TOP_MACROS_SVH
`define MULTI_REVOLUTION_BIT_VOTE_TOP_MACROS_SVH

`define MRBV_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MRBV_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mrbv_pkg.sv -----
package mrbv_pkg;

    localparam int MAX_REVS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 20;

    localparam int REV_W      = 4;
    localparam int MASK_W     = 8;
    localparam int VOTE_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 3;
    localparam int CONF_W     = 7;
    localparam int WEAK_W     = 20;
    localparam int MAJ_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_REV_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 1'd1;

    localparam logic [REV_W-1:0]  REV_COUNT_RST    = 4'd2;
    localparam logic [MASK_W-1:0] PRESENT_MASK_RST = 8'hFF;

    localparam logic [CONF_W-1:0] CONF_TIE = 7'd50;
    localparam int PCT       = 100;
    localparam int DIV_W     = 10;
    localparam int DIV_STEPS = 2;
    localparam int DIV_CYC   = DIV_W / DIV_STEPS;

    typedef struct packed {
        logic             bit_val;
        logic             weak_flag;
        logic             tie;
        logic [MAJ_W-1:0] major;
        logic             last;
    } vote_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] weak_bits;
        logic [WEAK_W-1:0] weak_total;
        logic [MAJ_W-1:0]  major;
        logic              tie;
        logic              last;
    } byte_t;

    typedef struct packed {
        logic idle;
        logic busy;
    } out_stat_t;

endpackage

// ----- hw/rtl/mrbv_front.sv -----
module mrbv_front
    import mrbv_pkg::*;
#(
    parameter int MAX_REVS = MAX_REVS_DEF,
    parameter int NW       = $clog2(MAX_REVS + 1)
)
(
    input  logic [REV_W-1:0]  num_revs,
    input  logic [MASK_W-1:0] present_mask,
    input  logic [VOTE_W-1:0] votes,
    input  logic              final_bit,
    output logic [NW-1:0]     n_eff,
    output vote_t             cls
);

    localparam int CMP_W = NW + 2;

    logic [VOTE_W-1:0] act;
    logic [MAJ_W-1:0]  ones;
    logic [MAJ_W-1:0]  zeros;
    logic [MAJ_W-1:0]  major;
    logic [CMP_W-1:0]  maj4;
    logic [CMP_W-1:0]  n3;

    always_comb
    begin
        if (num_revs < REV_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (32'(num_revs) > MAX_REVS)
        begin
            n_eff = NW'(MAX_REVS);
        end
        else
        begin
            n_eff = NW'(num_revs);
        end
    end

    always_comb
    begin
        ones  = '0;
        zeros = '0;
        for (int r = 0; r < VOTE_W; r++)
        begin
            act[r] = (32'(r) < 32'(n_eff)) && present_mask[r];
            ones   = ones  + MAJ_W'(act[r] &&  votes[r]);
            zeros  = zeros + MAJ_W'(act[r] && !votes[r]);
        end
    end

    assign major = (zeros > ones) ? zeros : ones;
    assign maj4  = CMP_W'(major) << 2;
    assign n3    = (CMP_W'(n_eff) << 1) + CMP_W'(n_eff);

    assign cls.bit_val   = ones > zeros;
    assign cls.tie       = ones == zeros;
    assign cls.major     = major;
    assign cls.last      = final_bit;
    assign cls.weak_flag = (ones == zeros)
                        || ((ones != '0) && (zeros != '0) && (maj4 < n3));

endmodule

// ----- hw/rtl/mrbv_fifo.sv -----
module mrbv_fifo
    import mrbv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  vote_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output vote_t head
);

    localparam int DEPTH = 2;

    vote_t      mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full      = cnt_reg == 2'(DEPTH);
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/mrbv_back.sv -----
module mrbv_back
    import mrbv_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  vote_t     head,
    input  out_stat_t stat,
    output logic      pop,
    output logic      load,
    output byte_t     byte_out
);

    logic [BYTE_W-1:0]     data_shift_reg;
    logic [BYTE_W-1:0]     data_shift_next;
    logic [BYTE_W-1:0]     weak_shift_reg;
    logic [BYTE_W-1:0]     weak_shift_next;
    logic [POS_W-1:0]      bit_pos_reg;
    logic [POS_W-1:0]      bit_pos_next;
    logic [COUNT_BITS-1:0] weak_cnt_reg;
    logic [COUNT_BITS-1:0] weak_cnt_next;

    logic [BYTE_W-1:0]     slot;
    logic [BYTE_W-1:0]     data_new;
    logic [BYTE_W-1:0]     weak_new;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                  closing;

    assign slot     = BYTE_W'(8'h80) >> bit_pos_reg;
    assign data_new = data_shift_reg | (head.bit_val ? slot : '0);
    assign weak_new = weak_shift_reg | (head.weak_flag ? slot : '0);
    assign cnt_new  = weak_cnt_reg + COUNT_BITS'(head.weak_flag && (weak_cnt_reg != '1));
    assign closing  = head.last || (bit_pos_reg == POS_W'(BYTE_W - 1));

    assign pop  = head_valid && (!closing || stat.idle);
    assign load = pop && closing;

    assign byte_out.data       = data_new;
    assign byte_out.weak_bits  = weak_new;
    assign byte_out.weak_total = WEAK_W'(cnt_new);
    assign byte_out.major      = head.major;
    assign byte_out.tie        = head.tie;
    assign byte_out.last       = head.last;

    always_comb
    begin
        data_shift_next = data_shift_reg;
        weak_shift_next = weak_shift_reg;
        bit_pos_next    = bit_pos_reg;
        weak_cnt_next   = weak_cnt_reg;
        if (pop)
        begin
            bit_pos_next  = bit_pos_reg + POS_W'(1);
            weak_cnt_next = cnt_new;
            if (closing)
            begin
                data_shift_next = '0;
                weak_shift_next = '0;
                if (head.last)
                begin
                    bit_pos_next  = '0;
                    weak_cnt_next = '0;
                end
            end
            else
            begin
                data_shift_next = data_new;
                weak_shift_next = weak_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_shift_reg <= '0;
            weak_shift_reg <= '0;
            bit_pos_reg    <= '0;
            weak_cnt_reg   <= '0;
        end
        else
        begin
            data_shift_reg <= data_shift_next;
            weak_shift_reg <= weak_shift_next;
            bit_pos_reg    <= bit_pos_next;
            weak_cnt_reg   <= weak_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/mrbv_out.sv -----
module mrbv_out
    import mrbv_pkg::*;
#(
    parameter int MAX_REVS = MAX_REVS_DEF,
    parameter int NW       = $clog2(MAX_REVS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  byte_t             byte_in,
    input  logic [NW-1:0]     n_eff,
    output out_stat_t         stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_byte,
    output logic [BYTE_W-1:0] weak_byte,
    output logic [CONF_W-1:0] confidence,
    output logic [WEAK_W-1:0] weak_total,
    output logic              track_end
);

    localparam int RW    = NW + 1;
    localparam int CNT_W = $clog2(DIV_CYC);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;

    byte_t            hold_reg;
    logic [DIV_W-1:0] quot_reg;
    logic [DIV_W-1:0] quot_next;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    rem_next;

    always_comb
    begin
        logic [RW-1:0]    t;
        logic [DIV_W-1:0] q;
        logic [RW-1:0]    r;
        q = quot_reg;
        r = rem_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            t = {r[RW-2:0], q[DIV_W-1]};
            if (t >= RW'(n_eff))
            begin
                r = t - RW'(n_eff);
                q = {q[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r = t;
                q = {q[DIV_W-2:0], 1'b0};
            end
        end
        quot_next = q;
        rem_next  = r;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(DIV_CYC - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && load)
        begin
            hold_reg <= byte_in;
            quot_reg <= DIV_W'(byte_in.major) * DIV_W'(PCT);
            rem_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign stat.idle = state_reg == ST_IDLE;
    assign stat.busy = state_reg == ST_DIV;

    assign out_valid  = state_reg == ST_HOLD;
    assign data_byte  = hold_reg.data;
    assign weak_byte  = hold_reg.weak_bits;
    assign weak_total = hold_reg.weak_total;
    assign track_end  = hold_reg.last;
    assign confidence = hold_reg.tie ? CONF_TIE : CONF_W'(quot_reg);

endmodule

// ----- hw/rtl/multi_revolution_bit_vote_top.sv -----
// Merges one track bit position per input beat from up to eight revolutions.
// Input channel: votes (bit r from revolution r) and final_bit, on in_valid /
// in_ready. Output channel: one beat per completed byte or at the final bit,
// carrying data_byte, weak_byte, confidence, weak_total and track_end, on
// out_valid / out_ready.
// Config: cfg_we writes cfg_data into register cfg_index (0: revolution count,
// 1: present mask); write only while the block is idle.
// A beat is classified on entry and waits in a two-entry queue; the packer
// takes one queued beat per cycle, so bit positions flow at one per cycle
// while no closing beat waits for the output stage. Closing a byte starts a
// confidence divide (2 quotient bits per cycle); the output beat is then held
// until out_ready. The packer only closes the next byte once the output stage
// is empty, so a new byte cannot close while the last one is still dividing
// or waiting for the receiver.
// A stalled receiver holds the output beat; the queue then fills and in_ready
// drops. Reset clears the partial byte, bit position, weak count, queue and
// output stage and loads revolution count 2 and present mask all ones.
module multi_revolution_bit_vote_top
    import mrbv_pkg::*;
#(
    parameter int MAX_REVS   = MAX_REVS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VOTE_W-1:0]     votes,
    input  logic                  final_bit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     data_byte,
    output logic [BYTE_W-1:0]     weak_byte,
    output logic [CONF_W-1:0]     confidence,
    output logic [WEAK_W-1:0]     weak_total,
    output logic                  track_end
);

`include "multi_revolution_bit_vote_top_macros.svh"

    localparam int NW = $clog2(MAX_REVS + 1);

    logic [REV_W-1:0]  num_revs_reg;
    logic [REV_W-1:0]  num_revs_next;
    logic [MASK_W-1:0] present_mask_reg;
    logic [MASK_W-1:0] present_mask_next;

    logic [NW-1:0] n_eff;
    vote_t         cls;
    vote_t         head;
    logic          q_full;
    logic          q_not_empty;
    logic          push;
    logic          pop;
    logic          load;
    byte_t         byte_bus;
    out_stat_t     stat;

    always_comb
    begin
        num_revs_next     = num_revs_reg;
        present_mask_next = present_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REV_COUNT:    num_revs_next     = cfg_data[REV_W-1:0];
                REG_PRESENT_MASK: present_mask_next = cfg_data[MASK_W-1:0];
                default:          num_revs_next     = num_revs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_revs_reg     <= REV_COUNT_RST;
            present_mask_reg <= PRESENT_MASK_RST;
        end
        else
        begin
            num_revs_reg     <= num_revs_next;
            present_mask_reg <= present_mask_next;
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    mrbv_front #(
        .MAX_REVS (MAX_REVS),
        .NW       (NW)
    ) u_front (
        .num_revs     (num_revs_reg),
        .present_mask (present_mask_reg),
        .votes        (votes),
        .final_bit    (final_bit),
        .n_eff        (n_eff),
        .cls          (cls)
    );

    mrbv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    mrbv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (head),
        .stat       (stat),
        .pop        (pop),
        .load       (load),
        .byte_out   (byte_bus)
    );

    mrbv_out #(
        .MAX_REVS (MAX_REVS),
        .NW       (NW)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .byte_in    (byte_bus),
        .n_eff      (n_eff),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .weak_byte  (weak_byte),
        .confidence (confidence),
        .weak_total (weak_total),
        .track_end  (track_end)
    );

    `MRBV_CHECK_SAME(a_conf_range, out_valid, confidence <= CONF_W'(PCT), "confidence above 100")
    `MRBV_CHECK_SAME(a_full_by_push, $fell(in_ready), $past(push), "queue filled without a push")
    `MRBV_CHECK_SAME(a_out_after_div, $rose(out_valid), $past(stat.busy), "result without divide")
    `MRBV_CHECK_NEXT(a_out_drains, out_valid && out_ready, !out_valid, "output beat repeated")

endmodule

// ----- verif/multi_revolution_bit_vote_top_tb.sv -----
module multi_revolution_bit_vote_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrbv_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int BATCH_BEATS   = 128;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] weak_bits;
        logic [CONF_W-1:0] conf;
        logic [WEAK_W-1:0] total;
        logic              track_end;
    } merged_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [VOTE_W-1:0]     votes;
    logic                  final_bit;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     data_byte;
    logic [BYTE_W-1:0]     weak_byte;
    logic [CONF_W-1:0]     confidence;
    logic [WEAK_W-1:0]     weak_total;
    logic                  track_end;

    // predictor copy of the block
    logic [REV_W-1:0]  num_revs_cfg = REV_COUNT_RST;
    logic [MASK_W-1:0] present_cfg  = PRESENT_MASK_RST;
    logic [BYTE_W-1:0] data_acc     = '0;
    logic [BYTE_W-1:0] weak_acc     = '0;
    logic [POS_W-1:0]  slot_idx     = '0;
    logic [WEAK_W-1:0] weak_run     = '0;

    merged_byte_t bytes_due[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int bytes_checked = 0;
    int beats_sent    = 0;
    int tracks_sent   = 0;
    int quiet_cycles  = 0;

    multi_revolution_bit_vote_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .votes      (votes),
        .final_bit  (final_bit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .weak_byte  (weak_byte),
        .confidence (confidence),
        .weak_total (weak_total),
        .track_end  (track_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void merge_position(input logic [VOTE_W-1:0] v, input logic fin);
        int           n;
        int           ones;
        int           zeros;
        int           major;
        int           conf;
        logic         bit_val;
        logic         is_weak;
        merged_byte_t mb;
        n = int'(num_revs_cfg);
        if (n < 2)
            n = 2;
        if (n > MAX_REVS_DEF)
            n = MAX_REVS_DEF;
        ones  = 0;
        zeros = 0;
        for (int r = 0; r < VOTE_W; r++)
        begin
            if (r < n && present_cfg[r])
            begin
                if (v[r])
                    ones++;
                else
                    zeros++;
            end
        end
        is_weak = 1'b0;
        if (ones > zeros)
        begin
            bit_val = 1'b1;
            major   = ones;
            conf    = (PCT * ones) / n;
        end
        else if (zeros > ones)
        begin
            bit_val = 1'b0;
            major   = zeros;
            conf    = (PCT * zeros) / n;
        end
        else
        begin
            bit_val = 1'b0;
            major   = ones;
            conf    = int'(CONF_TIE);
            is_weak = 1'b1;
        end
        if (ones > 0 && zeros > 0 && major * 4 < n * 3)
            is_weak = 1'b1;

        data_acc[7 - slot_idx] = bit_val;
        if (is_weak)
        begin
            weak_acc[7 - slot_idx] = 1'b1;
            if (weak_run != '1)
                weak_run++;
        end
        slot_idx++;

        if (!fin && slot_idx != 0)
            return;

        mb.data      = data_acc;
        mb.weak_bits = weak_acc;
        mb.conf      = conf[CONF_W-1:0];
        mb.total     = weak_run;
        mb.track_end = fin;
        bytes_due.push_back(mb);
        data_acc = '0;
        weak_acc = '0;
        if (fin)
        begin
            slot_idx = '0;
            weak_run = '0;
        end
    endfunction

    // receiver side: check each output beat, then pick next ready
    always @(posedge clk)
    begin : rx_check
        merged_byte_t due;
        merged_byte_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {data_byte, weak_byte, confidence, weak_total, track_end};
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte data=%h weak=%h conf=%0d total=%0d end=%b",
                         $time, data_byte, weak_byte, confidence, weak_total, track_end);
                mismatches++;
            end
            else
            begin
                due = bytes_due.pop_front();
                if (seen !== due)
                begin
                    $display("%0t: mismatch exp data=%h weak=%h conf=%0d total=%0d end=%b",
                             $time, due.data, due.weak_bits, due.conf, due.total,
                             due.track_end);
                    $display("%0t:          got data=%h weak=%h conf=%0d total=%0d end=%b",
                             $time, data_byte, weak_byte, confidence, weak_total, track_end);
                    mismatches++;
                end
            end
            bytes_checked++;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d bytes outstanding",
                         $time, STALL_LIMIT, bytes_due.size());
                $display("** multi_revolution_bit_vote_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_position(input logic [VOTE_W-1:0] v, input logic fin);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        votes     <= v;
        final_bit <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        merge_position(v, fin);
        beats_sent++;
        if (fin)
            tracks_sent++;
    endtask

    task automatic wait_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [REV_W-1:0] rev, input logic [MASK_W-1:0] mask);
        logic [CFG_DATA_W-1:0] rev_word;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        rev_word              = CFG_DATA_W'($urandom_range(255));
        rev_word[REV_W-1:0]   = rev;
        cfg_we    <= 1'b1;
        cfg_index <= REG_REV_COUNT;
        cfg_data  <= rev_word;
        @(posedge clk);
        cfg_index <= REG_PRESENT_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_we <= 1'b0;
        num_revs_cfg = rev;
        present_cfg  = mask;
    endtask

    task automatic test_reset_defaults;
        send_position(8'h00, 1'b0);
        send_position(8'h03, 1'b0);
        send_position(8'hFE, 1'b1);
    endtask

    task automatic test_vote_classes;
        set_config(4'd8, 8'hFF);
        send_position(8'hFF, 1'b0);
        send_position(8'h00, 1'b0);
        send_position(8'h0F, 1'b0);
        send_position(8'h1F, 1'b0);
        send_position(8'h3F, 1'b0);
        send_position(8'hE0, 1'b0);
        send_position(8'h7F, 1'b0);
        send_position(8'h80, 1'b1);
        // nobody votes
        set_config(4'd8, 8'h00);
        send_position(8'hAA, 1'b1);
        set_config(4'd8, 8'h55);
        send_position(8'hFF, 1'b0);
        send_position(8'h0F, 1'b1);
    endtask

    task automatic test_count_clamp;
        set_config(4'd0, 8'hFF);
        send_position(8'h01, 1'b1);
        set_config(4'd15, 8'hFF);
        send_position(8'h7F, 1'b1);
        set_config(4'd3, 8'hFF);
        send_position(8'hF8, 1'b1);
    endtask

    task automatic test_track_span;
        set_config(4'd4, 8'h0F);
        send_position(8'h03, 1'b0);
        send_position(8'h07, 1'b0);
        send_position(8'h0F, 1'b0);
        send_position(8'hF0, 1'b0);
        send_position(8'h01, 1'b0);
        send_position(8'h0E, 1'b0);
        send_position(8'h05, 1'b0);
        send_position(8'h08, 1'b0);
        send_position(8'h06, 1'b1);
    endtask

    task automatic test_random_traffic;
        int               idle_mix[4]  = '{0, 50, 0, 13};
        int               stall_mix[4] = '{0, 0, 50, 13};
        logic [REV_W-1:0] rev;
        logic [MASK_W-1:0] mask;
        logic [VOTE_W-1:0] v;
        logic             fin;
        for (int p = 0; p < 4; p++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                rev  = ($urandom_range(3) == 0) ? REV_W'($urandom_range(15))
                                                : REV_W'($urandom_range(2, MAX_REVS_DEF));
                mask = ($urandom_range(4) == 0) ? 8'hFF : MASK_W'($urandom_range(255));
                set_config(rev, mask);
                idle_pct  = idle_mix[p];
                stall_pct = stall_mix[p];
                for (int i = 0; i < BATCH_BEATS; i++)
                begin
                    if ($urandom_range(9) < 6)
                        v = ($urandom_range(1) ? 8'hFF : 8'h00)
                            ^ (8'($urandom) & 8'($urandom) & 8'($urandom));
                    else
                        v = VOTE_W'($urandom_range(255));
                    fin = (i == BATCH_BEATS - 1) || ($urandom_range(47) == 0);
                    send_position(v, fin);
                    if (b == 1 && i == BATCH_BEATS / 2)
                        wait_results();
                end
                idle_pct  = 0;
                stall_pct = 0;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_REV_COUNT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        votes     <= '0;
        final_bit <= 1'b0;
        out_ready <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_vote_classes();
        test_count_clamp();
        test_track_span();
        test_random_traffic();

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bit positions in %0d tracks, %0d merged bytes checked",
                 beats_sent, tracks_sent, bytes_checked);
        $display("ties, weak splits, no voters, count clamping, four handshake mixes");
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("** multi_revolution_bit_vote_top: PASSED **");
        else
            $display("** multi_revolution_bit_vote_top: FAILED **");
        $finish;
    end

endmodule
